/* src/euler_angle_rotation_update_top_assert.svh */
// Assertion macros for the Euler rotation block
`ifndef EULER_ANGLE_ROTATION_UPDATE_TOP_ASSERT_SVH
`define EULER_ANGLE_ROTATION_UPDATE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ERU_ASSERT_IMPL(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");
`define ERU_ASSERT_SEQ(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ERU_ASSERT_IMPL(label, cond)
`define ERU_ASSERT_SEQ(label, ante, cons)
`endif
`endif

/* src/eru_pkg.sv */
// Package: payload types, constants and fixed-point helpers
`timescale 1ns / 1ps
package eru_pkg;
   localparam int unsigned AngleWidth = 16;
   localparam int unsigned PipeDepth  = 9;
   localparam logic [14:0] Quarter = 15'd16384;
   localparam logic [14:0] SinC1 = 15'd25736;
   localparam logic [14:0] SinC3 = 15'd10512;
   localparam logic [10:0] SinC5 = 11'd1160;

   typedef struct packed {
      logic [15:0] pitch_angle;
      logic [15:0] yaw_angle;
      logic [15:0] roll_angle;
      logic signed [15:0] pitch_rate;
      logic signed [15:0] yaw_rate;
      logic signed [15:0] roll_rate;
   } req_item_type;

   typedef struct packed {
      logic [15:0] new_pitch;
      logic [15:0] new_yaw;
      logic [15:0] new_roll;
      logic signed [15:0] rot_r0c0;
      logic signed [15:0] rot_r0c1;
      logic signed [15:0] rot_r0c2;
      logic signed [15:0] rot_r1c0;
      logic signed [15:0] rot_r1c1;
      logic signed [15:0] rot_r1c2;
      logic signed [15:0] rot_r2c0;
      logic signed [15:0] rot_r2c1;
      logic signed [15:0] rot_r2c2;
   } rsp_item_type;

   // Q1.14 product rounded half up
   function automatic logic signed [17:0] qmul(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
      logic signed [31:0] p;
      p = a * b + 32'sd8192;
      return p[31:14];
   endfunction

   function automatic logic signed [15:0] sat_unit(input logic signed [18:0] v);
      if (v > 19'sd16384) return 16'sd16384;
      if (v < -19'sd16384) return -16'sd16384;
      return v[15:0];
   endfunction
endpackage

/* src/eru_advance.sv */
// Angle advance stage: scale rate, round, wrap
`timescale 1ns / 1ps
module eru_advance import eru_pkg::*; (
   input  logic clock,
   input  logic enable,
   input  logic [15:0] step_scale,
   input  logic [15:0] angle,
   input  logic signed [15:0] rate,
   output logic [15:0] new_angle
);
   logic signed [32:0] prod_ff, prod_in;
   logic [15:0] angle_ff;
   logic signed [32:0] rounded;
   assign prod_in = $signed({1'b0, step_scale}) * rate;
   assign rounded = prod_ff + 33'sd32768;
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff  <= prod_in;
         angle_ff <= angle;
         new_angle <= angle_ff + rounded[31:16];
      end
   end
endmodule

/* src/eru_sincos.sv */
// Pipelined quarter-wave polynomial sine
`timescale 1ns / 1ps
module eru_sincos import eru_pkg::*; (
   input  logic clock,
   input  logic enable,
   input  logic [15:0] angle,
   output logic signed [15:0] sine
);
   logic [14:0] x_in, x_ff, x2_ff, x3_ff, x4_ff;
   logic [1:0] q2_ff, q3_ff, q4_ff, q5_ff;
   logic [29:0] sq;
   logic [15:0] t2_ff, t2b_ff;
   logic [26:0] pa;
   logic [14:0] inner_ff;
   logic [31:0] pb;
   logic [14:0] mid_ff;
   logic [29:0] pc;
   logic [15:0] s;
   assign x_in = angle[14] ? (Quarter - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
   assign sq = x_ff * x_ff + 30'd8192;
   assign pa = t2_ff * SinC5 + 27'd8192;
   assign pb = t2b_ff * inner_ff + 32'd8192;
   assign pc = x4_ff * mid_ff + 30'd8192;
   assign s  = pc[29:14] > 16'(Quarter) ? 16'(Quarter) : pc[29:14];
   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;  q2_ff <= angle[15:14];
         t2_ff <= sq[29:14]; x2_ff <= x_ff; q3_ff <= q2_ff;
         inner_ff <= SinC3 - 15'(pa[26:14]); t2b_ff <= t2_ff;
         x3_ff <= x2_ff; q4_ff <= q3_ff;
         mid_ff <= SinC1 - 15'(pb[31:14]); x4_ff <= x3_ff; q5_ff <= q4_ff;
         sine <= q5_ff[1] ? -$signed(s) : $signed(s);
      end
   end
endmodule

/* src/eru_matrix.sv */
// Two-stage rotation matrix assembly from sines and cosines
`timescale 1ns / 1ps
module eru_matrix import eru_pkg::*; (
   input  logic clock,
   input  logic enable,
   input  logic signed [15:0] sp, cp, sy, cy, sr, cr,
   output logic signed [15:0] m [9]
);
   logic signed [15:0] srsp_ff, crsp_ff, sp_ff, cp_ff, sy_ff, cy_ff, sr_ff, cr_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         srsp_ff <= 16'(qmul(sr, sp));
         crsp_ff <= 16'(qmul(cr, sp));
         sp_ff <= sp; cp_ff <= cp; sy_ff <= sy; cy_ff <= cy; sr_ff <= sr; cr_ff <= cr;
         m[0] <= sat_unit(19'(qmul(cp_ff, cy_ff)));
         m[1] <= sat_unit(-19'(qmul(cp_ff, sy_ff)));
         m[2] <= sat_unit(19'(sp_ff));
         m[3] <= sat_unit(19'(qmul(cr_ff, sy_ff)) + 19'(qmul(srsp_ff, cy_ff)));
         m[4] <= sat_unit(19'(qmul(cr_ff, cy_ff)) - 19'(qmul(srsp_ff, sy_ff)));
         m[5] <= sat_unit(-19'(qmul(sr_ff, cp_ff)));
         m[6] <= sat_unit(19'(qmul(sr_ff, sy_ff)) - 19'(qmul(crsp_ff, cy_ff)));
         m[7] <= sat_unit(19'(qmul(sr_ff, cy_ff)) + 19'(qmul(crsp_ff, sy_ff)));
         m[8] <= sat_unit(19'(qmul(cr_ff, cp_ff)));
      end
   end
endmodule

/* src/euler_angle_rotation_update_top.sv */
// Top level: angle advance and rotation matrix pipeline
`timescale 1ns / 1ps
// Fully pipelined: one item per cycle while not stalled, through nine register
// stages (two for the angle advance, five for the sine polynomial, two for the
// matrix), the last of them being the output register.
// A stall freezes the whole pipeline; input is stalled only when the output
// register holds an item that is not being taken.
`include "euler_angle_rotation_update_top_assert.svh"
module euler_angle_rotation_update_top import eru_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic req_valid,
   output logic req_stall,
   input  req_item_type req_item,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_item_type rsp_item
);
   localparam int unsigned Lat = PipeDepth;
   logic [15:0] scale_ff;
   logic [Lat-1:0] vld_ff;
   logic enable;
   logic [15:0] np, ny, nr, cpa, cya, cra;
   logic signed [15:0] sp, cp, sy, cy, sr, cr;
   logic signed [15:0] m [9];
   logic [15:0] ang_d_ff [7][3];

   assign enable = !(vld_ff[Lat-1] && rsp_stall);
   assign req_stall = !enable;
   assign rsp_valid = vld_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
         vld_ff <= '0;
      end else begin
         if (csr_write_enable) scale_ff <= csr_write_data;
         if (enable) vld_ff <= {vld_ff[Lat-2:0], req_valid};
      end
   end

   eru_advance u_ap (.clock, .enable, .step_scale(scale_ff), .angle(req_item.pitch_angle),
      .rate(req_item.pitch_rate), .new_angle(np));
   eru_advance u_ay (.clock, .enable, .step_scale(scale_ff), .angle(req_item.yaw_angle),
      .rate(req_item.yaw_rate), .new_angle(ny));
   eru_advance u_ar (.clock, .enable, .step_scale(scale_ff), .angle(req_item.roll_angle),
      .rate(req_item.roll_rate), .new_angle(nr));

   assign cpa = np + 16'd16384;
   assign cya = ny + 16'd16384;
   assign cra = nr + 16'd16384;
   eru_sincos u_sp (.clock, .enable, .angle(np),  .sine(sp));
   eru_sincos u_cp (.clock, .enable, .angle(cpa), .sine(cp));
   eru_sincos u_sy (.clock, .enable, .angle(ny),  .sine(sy));
   eru_sincos u_cy (.clock, .enable, .angle(cya), .sine(cy));
   eru_sincos u_sr (.clock, .enable, .angle(nr),  .sine(sr));
   eru_sincos u_cr (.clock, .enable, .angle(cra), .sine(cr));

   eru_matrix u_mat (.clock, .enable, .sp, .cp, .sy, .cy, .sr, .cr, .m);

   // carry advanced angles alongside sine (5) and matrix (2) stages
   always_ff @(posedge clock) begin
      if (enable) begin
         ang_d_ff[0] <= '{np, ny, nr};
         for (int i = 1; i < 7; i++) ang_d_ff[i] <= ang_d_ff[i-1];
      end
   end
   assign rsp_item.new_pitch = ang_d_ff[6][0];
   assign rsp_item.new_yaw   = ang_d_ff[6][1];
   assign rsp_item.new_roll  = ang_d_ff[6][2];
   assign rsp_item.rot_r0c0 = m[0];
   assign rsp_item.rot_r0c1 = m[1];
   assign rsp_item.rot_r0c2 = m[2];
   assign rsp_item.rot_r1c0 = m[3];
   assign rsp_item.rot_r1c1 = m[4];
   assign rsp_item.rot_r1c2 = m[5];
   assign rsp_item.rot_r2c0 = m[6];
   assign rsp_item.rot_r2c1 = m[7];
   assign rsp_item.rot_r2c2 = m[8];

   `ERU_ASSERT_SEQ(a_stall_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))
   `ERU_ASSERT_IMPL(a_stall_link, req_stall == (rsp_valid && rsp_stall))
   `ERU_ASSERT_SEQ(a_freeze, req_stall, $stable(vld_ff))
endmodule
